/* hw/rtl/zsn_pkg.sv */
// Shared types and constants for the z-score normalizer.
// Item structs, controller/datapath command and status groups, widths.
// No dependencies.
package zsn_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int ADDR_W      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    // Arithmetic widths sized for the largest run (64 samples)
    localparam int N_W     = 7;   // sample count as a multiplier operand
    localparam int SUM_W   = 22;  // running sum, signed
    localparam int SQ_W    = 37;  // running sum of squares
    localparam int PROD_W  = 43;  // n * sum of squares
    localparam int DIFF_W  = 44;  // n * sumsq - sum * sum, signed
    localparam int DIV_W   = 60;  // divider dividend and quotient
    localparam int DSR_W   = 24;  // divider divisor
    localparam int ITER_W  = 6;
    localparam int RAD_W   = 48;  // square root radicand
    localparam int ROOT_W  = 24;

    localparam logic [ITER_W-1:0] MEAN_ITERS = ITER_W'(30);
    localparam logic [ITER_W-1:0] VAR_ITERS  = ITER_W'(60);
    localparam logic [ITER_W-1:0] Z_ITERS    = ITER_W'(38);

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_SIGMA_ZERO = 2'd1;
    localparam logic [1:0] ST_DROPPED    = 2'd2;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } zsn_in_t;

    typedef struct packed {
        logic signed [15:0] normalized;
        logic signed [23:0] mean_value;
        logic [23:0]        sigma_value;
        logic [1:0]         status;
        logic               last_out;
    } zsn_out_t;

    typedef struct packed {
        logic acc;         // take the input item
        logic mul_start;   // start n * sumsq and latch sum * sum
        logic var_start;   // start variance divide
        logic sqrt_start;  // start square root of variance quotient
        logic mean_start;  // start mean divide
        logic mean_cap;    // latch signed mean
        logic rd;          // read stored sample at emit index
        logic z_start;     // start normalize divide
        logic out_load;    // load result register, advance emit index
        logic clear;       // clear run state
    } zsn_cmd_t;

    typedef struct packed {
        logic mul_busy;
        logic div_busy;
        logic sqrt_busy;
        logic count_zero;
        logic last_idx;
        logic out_free;
    } zsn_stat_t;

endpackage

/* hw/rtl/zsn_div.sv */
// Serial restoring divider, one quotient bit per cycle.
// Dividend arrives left aligned; iters sets how many bits are produced.
// Depends on zsn_pkg.
module zsn_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [zsn_pkg::DIV_W-1:0]   dividend,
    input  logic [zsn_pkg::DSR_W-1:0]   divisor,
    input  logic [zsn_pkg::ITER_W-1:0]  iters,
    output logic                        busy,
    output logic [zsn_pkg::DIV_W-1:0]   quotient
);
    import zsn_pkg::*;

    logic [ITER_W-1:0] cnt_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  q_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [DSR_W-1:0]  rem_reg;

    logic [DSR_W:0]    shifted;
    logic [DSR_W+1:0]  trial;
    logic              fits;

    always_comb
    begin
        shifted = {rem_reg, dvd_reg[DIV_W-1]};
        trial   = {1'b0, shifted} - {2'b00, dsr_reg};
        fits    = !trial[DSR_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= iters;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            rem_reg <= fits ? trial[DSR_W-1:0] : shifted[DSR_W-1:0];
            q_reg   <= {q_reg[DIV_W-2:0], fits};
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = q_reg;

endmodule

/* hw/rtl/zsn_sqrt.sv */
// Serial integer square root, one root bit per cycle (floor).
// Radicand is taken two bits a step from the top.
// Depends on zsn_pkg.
module zsn_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [zsn_pkg::RAD_W-1:0]   radicand,
    output logic                        busy,
    output logic [zsn_pkg::ROOT_W-1:0]  root
);
    import zsn_pkg::*;

    localparam int CNT_W_SQ = $clog2(ROOT_W + 1);
    localparam int REM_W    = ROOT_W + 2;

    logic [CNT_W_SQ-1:0] cnt_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;

    logic [REM_W+1:0]    partial;
    logic [REM_W+1:0]    trial_sub;
    logic [REM_W+1:0]    diff;
    logic                fits;

    always_comb
    begin
        partial   = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial_sub = {2'b00, root_reg, 2'b01};
        diff      = partial - trial_sub;
        fits      = (partial >= trial_sub);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W_SQ'(ROOT_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? diff[REM_W-1:0] : partial[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign busy = (cnt_reg != '0);
    assign root = root_reg;

endmodule

/* hw/rtl/zsn_dp.sv */
// Datapath: sample store, accumulators, shift-add multiply, shared divider,
// square root and the result register. Driven by zsn_ctrl commands.
// Depends on zsn_pkg, zsn_div, zsn_sqrt.
module zsn_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  zsn_pkg::zsn_cmd_t  cmd,
    output zsn_pkg::zsn_stat_t stat,
    input  zsn_pkg::zsn_in_t   item,
    output zsn_pkg::zsn_out_t  result,
    output logic               result_valid,
    input  logic               result_ready
);
    import zsn_pkg::*;

    logic signed [15:0]       mem [MAX_SAMPLES];

    logic [CNT_W-1:0]         count_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic                     ovf_reg;
    logic [ADDR_W-1:0]        k_reg;
    logic [2:0]               mcnt_reg;
    logic [N_W-1:0]           nsh_reg;
    logic [PROD_W-1:0]        msh_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic signed [DIFF_W-1:0] ssq_reg;
    logic signed [23:0]       mean_reg;
    logic signed [15:0]       rd_reg;
    logic                     zneg_reg;
    zsn_out_t                 out_reg;
    logic                     out_valid_reg;

    logic signed [15:0]       x;
    logic signed [31:0]       xsq;
    logic                     wr;
    logic signed [DIFF_W-1:0] ssq_prod;
    logic [SUM_W-1:0]         sum_mag;
    logic [29:0]              mean_num;
    logic signed [DIFF_W-1:0] var_diff;
    logic [PROD_W-1:0]        var_num;
    logic [2*N_W-1:0]         n_sq;
    logic signed [24:0]       z_num;
    logic [24:0]              z_mag;
    logic [37:0]              z_div_num;

    logic                     div_start;
    logic [DIV_W-1:0]         div_dvd;
    logic [DSR_W-1:0]         div_dsr;
    logic [ITER_W-1:0]        div_iters;
    logic                     div_busy;
    logic [DIV_W-1:0]         div_q;
    logic                     sqrt_busy;
    logic [ROOT_W-1:0]        sigma;

    logic signed [15:0]       z_val;
    logic [1:0]               status_val;

    always_comb
    begin
        x         = item.sample;
        xsq       = 32'(x) * 32'(x);
        wr        = cmd.acc && (count_reg < CNT_W'(MAX_SAMPLES));
        ssq_prod  = DIFF_W'(sum_reg) * DIFF_W'(sum_reg);
        sum_mag   = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
        mean_num  = {sum_mag, 8'b0} + 30'(count_reg >> 1);
        var_diff  = $signed({1'b0, prod_reg}) - ssq_reg;
        var_num   = var_diff[DIFF_W-1] ? '0 : var_diff[PROD_W-1:0];
        n_sq      = (2*N_W)'(count_reg) * (2*N_W)'(count_reg);
        z_num     = $signed({rd_reg[15], rd_reg, 8'b0}) - $signed({mean_reg[23], mean_reg});
        z_mag     = z_num[24] ? (~z_num + 1'b1) : z_num;
        z_div_num = 38'({z_mag, 12'b0}) + 38'(sigma[ROOT_W-1:1]);
    end

    // Shared divider operand select
    always_comb
    begin
        div_start = cmd.mean_start || cmd.var_start || cmd.z_start;
        if (cmd.var_start)
        begin
            div_dvd   = {1'b0, var_num, 16'b0};
            div_dsr   = DSR_W'(n_sq);
            div_iters = VAR_ITERS;
        end
        else if (cmd.mean_start)
        begin
            div_dvd   = {mean_num, 30'b0};
            div_dsr   = DSR_W'(count_reg);
            div_iters = MEAN_ITERS;
        end
        else
        begin
            div_dvd   = {z_div_num, 22'b0};
            div_dsr   = sigma;
            div_iters = Z_ITERS;
        end
    end

    zsn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .iters    (div_iters),
        .busy     (div_busy),
        .quotient (div_q)
    );

    zsn_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (div_q[RAD_W-1:0]),
        .busy     (sqrt_busy),
        .root     (sigma)
    );

    // Saturate the normalize quotient and pick the status code
    always_comb
    begin
        if (sigma == '0)
        begin
            z_val = '0;
        end
        else if (!zneg_reg)
        begin
            z_val = (div_q > DIV_W'(32767)) ? 16'sh7FFF : $signed(div_q[15:0]);
        end
        else
        begin
            z_val = (div_q > DIV_W'(32768)) ? 16'sh8000 : $signed(~div_q[15:0] + 1'b1);
        end

        if (sigma == '0)
        begin
            status_val = ST_SIGMA_ZERO;
        end
        else if (ovf_reg)
        begin
            status_val = ST_DROPPED;
        end
        else
        begin
            status_val = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc)
            begin
                if (wr)
                begin
                    count_reg <= count_reg + 1'b1;
                    sum_reg   <= sum_reg + {{(SUM_W-16){x[15]}}, x};
                    sq_reg    <= sq_reg + SQ_W'(unsigned'(xsq));
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end

            if (cmd.mul_start)
            begin
                mcnt_reg <= 3'(N_W);
            end
            else if (mcnt_reg != '0)
            begin
                mcnt_reg <= mcnt_reg - 1'b1;
            end

            if (cmd.out_load && !cmd.clear)
            begin
                k_reg <= k_reg + 1'b1;
            end

            if (cmd.clear)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                sq_reg    <= '0;
                ovf_reg   <= 1'b0;
                k_reg     <= '0;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[count_reg[ADDR_W-1:0]] <= x;
        end
        if (cmd.rd)
        begin
            rd_reg <= mem[k_reg];
        end

        // n * sumsq by shift-add over the bits of n
        if (cmd.mul_start)
        begin
            nsh_reg  <= N_W'(count_reg);
            msh_reg  <= PROD_W'(sq_reg);
            prod_reg <= '0;
            ssq_reg  <= ssq_prod;
        end
        else if (mcnt_reg != '0)
        begin
            if (nsh_reg[0])
            begin
                prod_reg <= prod_reg + msh_reg;
            end
            nsh_reg <= nsh_reg >> 1;
            msh_reg <= msh_reg << 1;
        end

        if (cmd.mean_cap)
        begin
            mean_reg <= sum_reg[SUM_W-1] ? $signed(~div_q[23:0] + 1'b1) : $signed(div_q[23:0]);
        end

        if (cmd.z_start)
        begin
            zneg_reg <= z_num[24];
        end

        if (cmd.out_load)
        begin
            out_reg.normalized  <= z_val;
            out_reg.mean_value  <= mean_reg;
            out_reg.sigma_value <= sigma;
            out_reg.status      <= status_val;
            out_reg.last_out    <= stat.last_idx;
        end
    end

    always_comb
    begin
        stat.mul_busy   = (mcnt_reg != '0);
        stat.div_busy   = div_busy;
        stat.sqrt_busy  = sqrt_busy;
        stat.count_zero = (count_reg == '0);
        stat.last_idx   = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);
        stat.out_free   = !out_valid_reg || result_ready;
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

/* hw/rtl/zsn_ctrl.sv */
// Controller state machine: load phase, statistics sequence, emit loop.
// Issues zsn_cmd_t to the datapath and watches zsn_stat_t.
// Depends on zsn_pkg.
module zsn_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_last,
    output logic               item_ready,
    input  zsn_pkg::zsn_stat_t stat,
    output zsn_pkg::zsn_cmd_t  cmd
);
    import zsn_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_MUL_WAIT,
        S_VAR_WAIT,
        S_ROOT_WAIT,
        S_READ,
        S_Z_START,
        S_Z_WAIT,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.acc = 1'b1;
                    if (item_last)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                if (stat.count_zero)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_LOAD;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MUL_WAIT;
                end
            end
            S_MUL_WAIT:
            begin
                if (!stat.mul_busy)
                begin
                    cmd.var_start = 1'b1;
                    state_next    = S_VAR_WAIT;
                end
            end
            S_VAR_WAIT:
            begin
                // root reads the variance quotient as the mean divide starts
                if (!stat.div_busy)
                begin
                    cmd.sqrt_start = 1'b1;
                    cmd.mean_start = 1'b1;
                    state_next     = S_ROOT_WAIT;
                end
            end
            S_ROOT_WAIT:
            begin
                if (!stat.div_busy && !stat.sqrt_busy)
                begin
                    cmd.mean_cap = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_Z_START;
            end
            S_Z_START:
            begin
                cmd.z_start = 1'b1;
                state_next  = S_Z_WAIT;
            end
            S_Z_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // hold until the result register can take the item
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.last_idx)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/zscore_normalizer_unit.sv */
// Z-score normalizer top level: controller plus datapath.
// Depends on zsn_pkg, zsn_ctrl, zsn_dp.
//
// Usage:
//   Input channel (item_valid/item_ready/item) carries one signed sample and
//   a last flag. Samples are taken one per cycle while the block is loading.
//   Up to 64 samples are stored; further ones are dropped and flagged.
//   The item marked last closes the run: item_ready falls and the block
//   computes n*sumsq (shift-add), the variance divide and then square
//   root and mean divide side by side; after the first normalize divide
//   the first result is loaded into the result register.
//   Output channel (result_valid/result_ready/result) then gives one result
//   per stored sample in arrival order, each after its own normalize divide
//   on the one-bit-per-cycle shared divider. last_out marks the final
//   result; item_ready rises again as that result is loaded.
//   When the receiver stalls, the result register holds its item and the
//   emit loop waits; nothing is lost or repeated.
//   Reset clears the run state and the controller; the block comes out of
//   reset ready to load. Sample storage needs no clearing.
module zscore_normalizer_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  zsn_pkg::zsn_in_t  item,
    output logic              result_valid,
    input  logic              result_ready,
    output zsn_pkg::zsn_out_t result
);
    import zsn_pkg::*;

    zsn_cmd_t  cmd;
    zsn_stat_t stat;

    zsn_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_last  (item.last),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    zsn_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

/* hw/rtl/zsn_checker.sv */
// Port-level checks for zscore_normalizer_unit, attached by bind.
// Depends on zsn_pkg.
module zsn_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input zsn_pkg::zsn_in_t  item,
    input logic              result_valid,
    input logic              result_ready,
    input zsn_pkg::zsn_out_t result
);
    import zsn_pkg::*;

    // Stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // Run closes: input is not ready right after the last item is taken
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.last |=> !item_ready)
        else $error("input taken after last item");

    // Mid-run results never overlap the load phase
    a_emit_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_out |-> !item_ready)
        else $error("input ready during emit");

    // Zero sigma gives zero output with its status
    a_sigma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.sigma_value == '0 |->
            result.normalized == '0 && result.status == ST_SIGMA_ZERO)
        else $error("zero sigma result malformed");

    // Sigma-zero status only when sigma is zero
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.sigma_value != '0 |->
            result.status == ST_OK || result.status == ST_DROPPED)
        else $error("bad status code");

endmodule

bind zscore_normalizer_unit zsn_checker u_zsn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

/* test/zscore_normalizer_unit_tb.sv */
// Self-checking testbench for the z-score normalizer: directed table, then random runs.
// Checks each result against an in-bench predictor of mean, sigma and Q4.12 output.
// Depends on zsn_pkg and zscore_normalizer_unit.
module zscore_normalizer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import zsn_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 310;
    localparam int QUIET_AFTER  = 250;
    localparam int REPORT_MAX   = 10;
    localparam int DRAIN_CYCLES = 200;

    typedef enum int {RUN_FULL, RUN_NARROW, RUN_FLAT} run_kind_t;

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
        bit                 typed;
        logic signed [15:0] normalized;
        logic signed [23:0] mean_value;
        logic [23:0]        sigma_value;
        logic [1:0]         status;
    } dir_row_t;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     item_valid   = 1'b0;
    logic     item_ready;
    zsn_in_t  item         = '0;
    logic     result_valid;
    logic     result_ready = 1'b0;
    zsn_out_t result;

    dir_row_t directed_rows[$];
    zsn_out_t pending_results[$];

    // Predictor copy of the run state
    logic signed [15:0] held_samples[MAX_SAMPLES];
    int                 held_rows[MAX_SAMPLES];
    int                 held_count   = 0;
    longint             acc_sum      = 0;
    longint             acc_sqsum    = 0;
    bit                 dropped_any  = 1'b0;

    int error_count   = 0;
    int cycle_count   = 0;
    bit quiet_phase   = 1'b0;
    bit long_hold_req = 1'b0;

    zscore_normalizer_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Nearest integer quotient, ties away from zero; den is positive.
    function automatic longint div_nearest(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint root_floor(input longint v);
        longint res;
        longint cand;
        res = 0;
        // radicand stays below 2**58, so the root fits in 30 bits
        for (int b = 29; b >= 0; b--)
        begin
            cand = res | (longint'(1) << b);
            if (cand * cand <= v)
                res = cand;
        end
        return res;
    endfunction

    function automatic void clear_run_state();
        held_count  = 0;
        acc_sum     = 0;
        acc_sqsum   = 0;
        dropped_any = 1'b0;
    endfunction

    // Update the run state with one accepted item; on last, queue the run's results.
    function automatic void predict_sample(input logic signed [15:0] x, input logic lst,
                                           input int row);
        longint   n;
        longint   mean;
        longint   diff;
        longint   sigma;
        longint   z;
        logic [1:0] run_status;
        zsn_out_t r;
        if (held_count < MAX_SAMPLES)
        begin
            held_samples[held_count] = x;
            held_rows[held_count]    = row;
            held_count++;
            acc_sum   += longint'(x);
            acc_sqsum += longint'(x) * longint'(x);
        end
        else
        begin
            dropped_any = 1'b1;
        end
        if (!lst)
            return;
        if (held_count == 0)
        begin
            clear_run_state();
            return;
        end
        n    = held_count;
        mean = div_nearest(acc_sum * 256, n);
        diff = n * acc_sqsum - acc_sum * acc_sum;
        if (diff < 0)
            diff = 0;
        sigma = root_floor((diff << 16) / (n * n));
        if (sigma == 0)
            run_status = ST_SIGMA_ZERO;
        else if (dropped_any)
            run_status = ST_DROPPED;
        else
            run_status = ST_OK;
        for (int k = 0; k < held_count; k++)
        begin
            z = 0;
            if (sigma != 0)
            begin
                z = div_nearest((longint'(held_samples[k]) * 256 - mean) * 4096, sigma);
                if (z > 32767)
                    z = 32767;
                if (z < -32768)
                    z = -32768;
            end
            r.normalized  = z[15:0];
            r.mean_value  = mean[23:0];
            r.sigma_value = sigma[23:0];
            r.status      = run_status;
            r.last_out    = (k == held_count - 1);
            // typed rows carry their own expected values
            if (held_rows[k] >= 0 && directed_rows[held_rows[k]].typed)
            begin
                r.normalized  = directed_rows[held_rows[k]].normalized;
                r.mean_value  = directed_rows[held_rows[k]].mean_value;
                r.sigma_value = directed_rows[held_rows[k]].sigma_value;
                r.status      = directed_rows[held_rows[k]].status;
            end
            pending_results.insert(pending_results.size(), r);
        end
        clear_run_state();
    endfunction

    function automatic void add_row(input logic signed [15:0] sample, input logic lst,
                                    input bit typed, input logic signed [15:0] normalized,
                                    input logic signed [23:0] mean_value,
                                    input logic [23:0] sigma_value, input logic [1:0] status);
        dir_row_t row;
        row.sample      = sample;
        row.last        = lst;
        row.typed       = typed;
        row.normalized  = normalized;
        row.mean_value  = mean_value;
        row.sigma_value = sigma_value;
        row.status      = status;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void build_directed();
        // flat pair: sigma zero
        add_row(16'sd5, 1'b0, 1'b1, 16'sd0, 24'd1280, 24'd0, ST_SIGMA_ZERO);
        add_row(16'sd5, 1'b1, 1'b1, 16'sd0, 24'd1280, 24'd0, ST_SIGMA_ZERO);
        // single sample at the top of the range
        add_row(16'sh7FFF, 1'b1, 1'b1, 16'sd0, 24'h7FFF00, 24'd0, ST_SIGMA_ZERO);
        // flat pair at the bottom of the range
        add_row(16'sh8000, 1'b0, 1'b1, 16'sd0, 24'h800000, 24'd0, ST_SIGMA_ZERO);
        add_row(16'sh8000, 1'b1, 1'b1, 16'sd0, 24'h800000, 24'd0, ST_SIGMA_ZERO);
        // both extremes: largest sigma, exactly minus and plus one
        add_row(16'sh8000, 1'b0, 1'b1, 16'shF000, 24'hFFFF80, 24'd8388480, ST_OK);
        add_row(16'sh7FFF, 1'b1, 1'b1, 16'sh1000, 24'hFFFF80, 24'd8388480, ST_OK);
        add_row(16'sd0, 1'b0, 1'b0, '0, '0, '0, ST_OK);
        add_row(16'sd1, 1'b0, 1'b0, '0, '0, '0, ST_OK);
        add_row(16'sd2, 1'b0, 1'b0, '0, '0, '0, ST_OK);
        add_row(16'sd3, 1'b1, 1'b0, '0, '0, '0, ST_OK);
        add_row(16'sh5555, 1'b0, 1'b0, '0, '0, '0, ST_OK);
        add_row(16'shAAAA, 1'b1, 1'b0, '0, '0, '0, ST_OK);
        add_row(16'sd100, 1'b0, 1'b0, '0, '0, '0, ST_OK);
        add_row(-16'sd100, 1'b0, 1'b0, '0, '0, '0, ST_OK);
        add_row(16'sd1, 1'b1, 1'b0, '0, '0, '0, ST_OK);
        add_row(16'sd0, 1'b1, 1'b1, 16'sd0, 24'd0, 24'd0, ST_SIGMA_ZERO);
    endfunction

    task automatic send_item(input logic signed [15:0] x, input logic lst, input int row);
        int      gap;
        zsn_in_t it;
        gap = (!quiet_phase && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        it.sample = x;
        it.last   = lst;
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        predict_sample(x, lst, row);
    endtask

    task automatic send_run(input int run_len, input run_kind_t kind);
        int center;
        int spread;
        int v;
        center = int'($urandom_range(0, 65535)) - 32768;
        spread = $urandom_range(1, 300);
        for (int k = 0; k < run_len; k++)
        begin
            case (kind)
                RUN_FULL:   v = int'($signed(16'($urandom())));
                RUN_NARROW: v = center + int'($urandom_range(0, 2 * spread)) - spread;
                default:    v = center;
            endcase
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            send_item(v[15:0], k == run_len - 1, -1);
        end
    endtask

    // Receiver: short random stalls, one long hold-off on request, none at the end.
    initial
    begin
        int  idle_left;
        bit  hold_done;
        idle_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                idle_left = LONG_HOLD;
            end
            if (idle_left > 0)
            begin
                idle_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 5) == 0)
                    idle_left = $urandom_range(1, 5);
            end
        end
    end

    always @(posedge clk)
    begin : check_result
        zsn_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("unexpected item: norm %0d mean %0d sigma %0d status %0d last %0b",
                             result.normalized, result.mean_value, result.sigma_value,
                             result.status, result.last_out);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.normalized !== want.normalized ||
                    result.mean_value !== want.mean_value ||
                    result.sigma_value !== want.sigma_value ||
                    result.status !== want.status ||
                    result.last_out !== want.last_out)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                    begin
                        $display("mismatch: norm %0d/%0d mean %0d/%0d",
                                 result.normalized, want.normalized,
                                 result.mean_value, want.mean_value);
                        $display("  sigma %0d/%0d status %0d/%0d last %0b/%0b",
                                 result.sigma_value, want.sigma_value,
                                 result.status, want.status,
                                 result.last_out, want.last_out);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int        random_sent;
        int        run_len;
        int        pick;
        run_kind_t kind;
        random_sent = 0;
        build_directed();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < directed_rows.size(); i++)
            send_item(directed_rows[i].sample, directed_rows[i].last, i);

        // overfill the store: the last sample is dropped
        send_run(MAX_SAMPLES + 1, RUN_FULL);
        random_sent += MAX_SAMPLES + 1;
        // hold the receiver while this run emits and the sender keeps offering
        long_hold_req = 1'b1;
        // flat overfilled run: sigma zero outranks the drop flag
        send_run(MAX_SAMPLES + 2, RUN_FLAT);
        random_sent += MAX_SAMPLES + 2;

        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent >= QUIET_AFTER)
                quiet_phase = 1'b1;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, MAX_SAMPLES + 3)
                                                  : $urandom_range(1, 8);
            pick = $urandom_range(0, 9);
            kind = (pick < 5) ? RUN_FULL : (pick < 8) ? RUN_NARROW : RUN_FLAT;
            send_run(run_len, kind);
            random_sent += run_len;
        end
        @(negedge clk);
        item_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/zsn_pkg.sv
hw/rtl/zsn_div.sv
hw/rtl/zsn_sqrt.sv
hw/rtl/zsn_dp.sv
hw/rtl/zsn_ctrl.sv
hw/rtl/zscore_normalizer_unit.sv
hw/rtl/zsn_checker.sv
test/zscore_normalizer_unit_tb.sv
